// ===== rtl/cec_bit_timing_receiver_core_macros.svh =====
// Assertion macros used by the checker file of the CEC bit timing receiver.
`ifndef CEC_BIT_TIMING_RECEIVER_CORE_MACROS_SVH
`define CEC_BIT_TIMING_RECEIVER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBTR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbtr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CBTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbtr assertion failed");

`endif

// ===== rtl/cbtr_pkg.sv =====
package cbtr_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TICK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD_MIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD_MAX   = 3'd6;

    localparam logic [7:0] TICK_LIMIT      = 8'd255;
    localparam logic [3:0] LAST_SLOT       = 4'd9;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_EDGE   = 2'd1;
    localparam logic [1:0] ERR_TOO_SHORT = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_BITS  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] sample_tick;
        logic [7:0] start_low_min;
        logic [7:0] start_low_max;
        logic [7:0] start_period_min;
        logic [7:0] start_period_max;
        logic [7:0] bit_period_min;
        logic [7:0] bit_period_max;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic frame_active;
    } in_item_t;

    typedef struct packed {
        logic       bit_valid;
        logic       bit_value;
        logic       start_seen;
        logic [1:0] error_code;
        logic [3:0] slot_index;
        logic       receiving;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic pop;
    } buf_ctrl_t;

endpackage

// ===== rtl/cbtr_cfg_regs.sv =====
module cbtr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [cbtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    output cbtr_pkg::cfg_t                cfg
);
    import cbtr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SAMPLE_TICK:      cfg_next.sample_tick      = cfg_data;
                REG_START_LOW_MIN:    cfg_next.start_low_min    = cfg_data;
                REG_START_LOW_MAX:    cfg_next.start_low_max    = cfg_data;
                REG_START_PERIOD_MIN: cfg_next.start_period_min = cfg_data;
                REG_START_PERIOD_MAX: cfg_next.start_period_max = cfg_data;
                REG_BIT_PERIOD_MIN:   cfg_next.bit_period_min   = cfg_data;
                REG_BIT_PERIOD_MAX:   cfg_next.bit_period_max   = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_tick      <= 8'd3;
            cfg_reg.start_low_min    <= 8'd11;
            cfg_reg.start_low_max    <= 8'd14;
            cfg_reg.start_period_min <= 8'd14;
            cfg_reg.start_period_max <= 8'd16;
            cfg_reg.bit_period_min   <= 8'd6;
            cfg_reg.bit_period_max   <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/cbtr_timing.sv =====
module cbtr_timing (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  cbtr_pkg::in_item_t  item,
    input  cbtr_pkg::cfg_t      cfg,
    output cbtr_pkg::out_item_t result
);
    import cbtr_pkg::*;

    logic [7:0] tick_count_reg;
    logic [7:0] tick_count_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       prev_level_reg;
    logic [7:0] period_min_reg;
    logic [7:0] period_min_next;
    logic [7:0] period_max_reg;
    logic [7:0] period_max_next;
    logic [3:0] bit_slot_reg;
    logic [3:0] bit_slot_next;

    logic [7:0] tick_inc;
    logic       sample_hit;
    logic       start_hit;
    logic [1:0] err;

    always_comb
    begin
        tick_inc        = (tick_count_reg < TICK_LIMIT) ? tick_count_reg + 8'd1 : tick_count_reg;
        tick_count_next = tick_inc;
        phase_next      = phase_reg;
        period_min_next = period_min_reg;
        period_max_next = period_max_reg;
        bit_slot_next   = bit_slot_reg;
        start_hit       = 1'b0;
        err             = ERR_NONE;

        sample_hit = (phase_reg == PH_BITS) && (tick_inc == cfg.sample_tick);
        if (sample_hit && !item.frame_active)
        begin
            phase_next = PH_IDLE;
        end

        if (item.line_level == prev_level_reg)
        begin
            if (tick_inc > period_max_reg)
            begin
                err        = ERR_NO_EDGE;
                phase_next = PH_IDLE;
            end
        end
        else if (!item.line_level)
        begin
            bit_slot_next = (bit_slot_reg >= LAST_SLOT) ? 4'd0 : bit_slot_reg + 4'd1;
            if (tick_inc < period_min_reg)
            begin
                err        = ERR_TOO_SHORT;
                phase_next = PH_IDLE;
            end
            else if (phase_next == PH_START)
            begin
                start_hit       = 1'b1;
                bit_slot_next   = 4'd0;
                phase_next      = PH_BITS;
                period_min_next = cfg.bit_period_min;
                period_max_next = cfg.bit_period_max;
            end
            tick_count_next = 8'd0;
        end
        else
        begin
            if ((tick_inc >= cfg.start_low_min) && (tick_inc <= cfg.start_low_max))
            begin
                phase_next      = PH_START;
                period_min_next = cfg.start_period_min;
                period_max_next = cfg.start_period_max;
            end
        end
    end

    always_comb
    begin
        result.bit_valid  = sample_hit;
        result.bit_value  = sample_hit & item.line_level;
        result.start_seen = start_hit;
        result.error_code = err;
        result.slot_index = bit_slot_next;
        result.receiving  = (phase_next == PH_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= 8'd0;
            phase_reg      <= PH_IDLE;
            prev_level_reg <= 1'b0;
            period_min_reg <= 8'd0;
            period_max_reg <= 8'd0;
            bit_slot_reg   <= 4'd0;
        end
        else if (advance)
        begin
            tick_count_reg <= tick_count_next;
            phase_reg      <= phase_next;
            prev_level_reg <= item.line_level;
            period_min_reg <= period_min_next;
            period_max_reg <= period_max_next;
            bit_slot_reg   <= bit_slot_next;
        end
    end

endmodule

// ===== rtl/cbtr_out_buf.sv =====
module cbtr_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  cbtr_pkg::buf_ctrl_t ctrl,
    input  cbtr_pkg::out_item_t item,
    output logic                full,
    output logic                not_empty,
    output cbtr_pkg::out_item_t head
);
    import cbtr_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    out_item_t  head_reg;
    out_item_t  head_next;
    out_item_t  tail_reg;
    out_item_t  tail_next;

    always_comb
    begin
        count_next = count_reg + {1'b0, ctrl.push} - {1'b0, ctrl.pop};
        head_next  = head_reg;
        tail_next  = tail_reg;
        if (ctrl.pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_next = tail_reg;
            end
            else if (ctrl.push)
            begin
                head_next = item;
            end
        end
        else if (ctrl.push)
        begin
            if (count_reg == 2'd0)
            begin
                head_next = item;
            end
            else
            begin
                tail_next = item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = head_reg;

endmodule

// ===== rtl/cec_bit_timing_receiver_core.sv =====
// Channel   Handshake              Payload
// in        in_valid / in_stall    in_data    (line_level, frame_active)
// out       out_valid / out_stall  out_data   (bit, start, error, slot, receiving)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each input transaction is processed combinationally and its result is registered in the result buffer.
// A new transaction can be taken every cycle; the two-entry result buffer lets one
// result wait while the next one is produced, and in_stall rises only when it is full.
// Reset clears the line state and the buffer and loads the register defaults.
// Configuration writes are always ready and take effect on the next cycle.
module cec_bit_timing_receiver_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  cbtr_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output cbtr_pkg::out_item_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cbtr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import cbtr_pkg::*;

    cfg_t      cfg;
    out_item_t result;
    buf_ctrl_t ctrl;
    logic      buf_full;
    logic      buf_not_empty;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign out_valid = buf_not_empty;
    assign ctrl.push = in_valid && !buf_full;
    assign ctrl.pop  = buf_not_empty && !out_stall;

    cbtr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cbtr_timing u_timing (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (ctrl.push),
        .item    (in_data),
        .cfg     (cfg),
        .result  (result)
    );

    cbtr_out_buf u_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .item      (result),
        .full      (buf_full),
        .not_empty (buf_not_empty),
        .head      (out_data)
    );

endmodule

// ===== rtl/cbtr_checker.sv =====
`include "cec_bit_timing_receiver_core_macros.svh"

module cbtr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input cbtr_pkg::out_item_t out_data
);
    import cbtr_pkg::*;

    `CBTR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `CBTR_ASSERT_SAME(a_slot_range, clk, rst_n, out_valid, out_data.slot_index <= LAST_SLOT)
    `CBTR_ASSERT_SAME(a_start_enters_bits, clk, rst_n, out_valid && out_data.start_seen, out_data.receiving && (out_data.slot_index == 4'd0) && (out_data.error_code == ERR_NONE))
    `CBTR_ASSERT_SAME(a_error_leaves_bits, clk, rst_n, out_valid && (out_data.error_code != ERR_NONE), !out_data.receiving && !out_data.start_seen)

endmodule

bind cec_bit_timing_receiver_core cbtr_checker u_cbtr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbtr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int RUN_CAP        = 40;

    localparam in_item_t LINE_LO     = '{line_level: 1'b0, frame_active: 1'b1};
    localparam in_item_t LINE_HI     = '{line_level: 1'b1, frame_active: 1'b1};
    localparam in_item_t LINE_LO_END = '{line_level: 1'b0, frame_active: 1'b0};
    localparam in_item_t LINE_HI_END = '{line_level: 1'b1, frame_active: 1'b0};

    localparam out_item_t STATUS_QUIET = '{bit_valid: 1'b0, bit_value: 1'b0,
        start_seen: 1'b0, error_code: ERR_NONE, slot_index: 4'd0, receiving: 1'b0};
    localparam out_item_t STATUS_NO_EDGE = '{bit_valid: 1'b0, bit_value: 1'b0,
        start_seen: 1'b0, error_code: ERR_NO_EDGE, slot_index: 4'd0, receiving: 1'b0};
    localparam out_item_t STATUS_SHORT_SLOT1 = '{bit_valid: 1'b0, bit_value: 1'b0,
        start_seen: 1'b0, error_code: ERR_TOO_SHORT, slot_index: 4'd1, receiving: 1'b0};

    typedef struct {
        in_item_t  stim;
        int        count;
        bit        typed;
        out_item_t want;
    } line_step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    logic                 quiet = 1'b0;
    logic                 hold_pending = 1'b0;
    bit                   hold_done = 1'b0;
    int                   idle_cycles = 0;
    int                   mismatches = 0;
    int                   items_sent = 0;

    logic [7:0]           rx_regs [0:6];
    logic [7:0]           rx_ticks;
    phase_t               rx_phase;
    logic                 rx_prev_level;
    logic [7:0]           rx_period_min;
    logic [7:0]           rx_period_max;
    logic [3:0]           rx_slot;

    out_item_t            expected_rx_status [$];

    cec_bit_timing_receiver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t predict_rx_status(in_item_t it);
        out_item_t  r;
        phase_t     ph;
        logic [3:0] next_slot;
        r = STATUS_QUIET;
        ph = rx_phase;
        if (rx_ticks != TICK_LIMIT)
            rx_ticks = rx_ticks + 8'd1;
        if (ph == PH_BITS && rx_ticks == rx_regs[REG_SAMPLE_TICK])
        begin
            r.bit_valid = 1'b1;
            r.bit_value = it.line_level;
            if (!it.frame_active)
                ph = PH_IDLE;
        end
        if (it.line_level == rx_prev_level)
        begin
            if (rx_ticks > rx_period_max)
            begin
                r.error_code = ERR_NO_EDGE;
                ph = PH_IDLE;
            end
        end
        else if (!it.line_level)
        begin
            next_slot = (rx_slot >= LAST_SLOT) ? 4'd0 : rx_slot + 4'd1;
            if (rx_ticks < rx_period_min)
            begin
                r.error_code = ERR_TOO_SHORT;
                ph = PH_IDLE;
            end
            else if (ph == PH_START)
            begin
                r.start_seen = 1'b1;
                next_slot = 4'd0;
                ph = PH_BITS;
                rx_period_min = rx_regs[REG_BIT_PERIOD_MIN];
                rx_period_max = rx_regs[REG_BIT_PERIOD_MAX];
            end
            rx_slot = next_slot;
            rx_ticks = 8'd0;
        end
        else if (rx_ticks >= rx_regs[REG_START_LOW_MIN] &&
                 rx_ticks <= rx_regs[REG_START_LOW_MAX])
        begin
            ph = PH_START;
            rx_period_min = rx_regs[REG_START_PERIOD_MIN];
            rx_period_max = rx_regs[REG_START_PERIOD_MAX];
        end
        rx_phase = ph;
        rx_prev_level = it.line_level;
        r.slot_index = rx_slot;
        r.receiving = (ph == PH_BITS);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int pick(int lo, int hi);
        int a;
        int b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        if (a < 1)
            a = 1;
        if (b > RUN_CAP)
            b = RUN_CAP;
        if (a > b)
            a = b;
        return $urandom_range(b, a);
    endfunction

    function automatic int nudge(int v);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            v = v + 2;
        else if (r == 1)
            v = v - 2;
        else if (r == 2)
            v = v + 1;
        else if (r == 3)
            v = v - 1;
        return (v < 1) ? 1 : v;
    endfunction

    function automatic cfg_t random_timing_cfg();
        cfg_t c;
        c.sample_tick      = 8'($urandom_range(1, 5));
        c.start_low_min    = 8'($urandom_range(2, 9));
        c.start_low_max    = c.start_low_min + 8'($urandom_range(0, 3));
        c.start_period_min = c.start_low_max + 8'($urandom_range(1, 3));
        c.start_period_max = c.start_period_min + 8'($urandom_range(0, 3));
        c.bit_period_min   = 8'($urandom_range(3, 7));
        c.bit_period_max   = c.bit_period_min + 8'($urandom_range(0, 4));
        return c;
    endfunction

    task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
        out_item_t predicted;
        while (!quiet && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_rx_status(it);
        expected_rx_status.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic send_run(logic lvl, logic act, int n);
        in_item_t it;
        it = '{line_level: lvl, frame_active: act};
        repeat (n)
            send_item(it);
    endtask

    task automatic send_frame();
        int   low_n;
        int   span;
        int   n_bits;
        int   p;
        int   l;
        int   i;
        logic act;
        send_run(1'b1, 1'b1, $urandom_range(1, 4));
        low_n = nudge(pick(rx_regs[REG_START_LOW_MIN], rx_regs[REG_START_LOW_MAX]));
        span = nudge(pick(rx_regs[REG_START_PERIOD_MIN], rx_regs[REG_START_PERIOD_MAX]));
        if (span <= low_n)
            span = low_n + 1;
        send_run(1'b0, 1'b1, low_n);
        send_run(1'b1, 1'b1, span - low_n);
        n_bits = $urandom_range(1, 14);
        for (i = 0; i < n_bits; i++)
        begin
            p = nudge(pick(rx_regs[REG_BIT_PERIOD_MIN], rx_regs[REG_BIT_PERIOD_MAX]));
            if (p < 2)
                p = 2;
            l = $urandom_range(1, p - 1);
            act = (i != n_bits - 1) && ($urandom_range(0, 19) != 0);
            send_run(1'b0, act, l);
            send_run(1'b1, act, p - l);
        end
    endtask

    task automatic send_noise();
        int len;
        len = ($urandom_range(0, 49) == 0) ? 260 : $urandom_range(1, 20);
        send_run(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), len);
    endtask

    task automatic run_random(int n);
        int stop;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            if ($urandom_range(0, 99) < 75)
                send_frame();
            else
                send_noise();
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_rx_status.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        rx_regs[idx] = val;
    endtask

    task automatic write_config(cfg_t c);
        wait_drained();
        repeat (3)
            @(posedge clk);
        write_reg(REG_SAMPLE_TICK, c.sample_tick);
        write_reg(REG_START_LOW_MIN, c.start_low_min);
        write_reg(REG_START_LOW_MAX, c.start_low_max);
        write_reg(REG_START_PERIOD_MIN, c.start_period_min);
        write_reg(REG_START_PERIOD_MAX, c.start_period_max);
        write_reg(REG_BIT_PERIOD_MIN, c.bit_period_min);
        write_reg(REG_BIT_PERIOD_MAX, c.bit_period_max);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 14);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rx_status.size() == 0)
            begin
                $error("result transaction with no expected status pending");
                mismatches++;
            end
            else
            begin
                want = expected_rx_status.pop_front();
                check_field("bit_valid", want.bit_valid, out_data.bit_valid);
                check_field("bit_value", want.bit_value, out_data.bit_value);
                check_field("start_seen", want.start_seen, out_data.start_seen);
                check_field("error_code", want.error_code, out_data.error_code);
                check_field("slot_index", want.slot_index, out_data.slot_index);
                check_field("receiving", want.receiving, out_data.receiving);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        line_step_t directed [11];
        cfg_t       c;
        int         i;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;

        rx_regs[REG_SAMPLE_TICK] = 8'd3;
        rx_regs[REG_START_LOW_MIN] = 8'd11;
        rx_regs[REG_START_LOW_MAX] = 8'd14;
        rx_regs[REG_START_PERIOD_MIN] = 8'd14;
        rx_regs[REG_START_PERIOD_MAX] = 8'd16;
        rx_regs[REG_BIT_PERIOD_MIN] = 8'd6;
        rx_regs[REG_BIT_PERIOD_MAX] = 8'd10;
        rx_ticks = 8'd0;
        rx_phase = PH_IDLE;
        rx_prev_level = 1'b0;
        rx_period_min = 8'd0;
        rx_period_max = 8'd0;
        rx_slot = 4'd0;

        // A steady low after reset hits the zero idle bounds, then a start bit is
        // built, one bit is sampled as the frame ends, and a short period follows.
        directed = '{
            '{LINE_LO,      1, 1'b1, STATUS_NO_EDGE},
            '{LINE_HI,      1, 1'b1, STATUS_QUIET},
            '{LINE_LO,      1, 1'b0, STATUS_QUIET},
            '{LINE_LO,     11, 1'b0, STATUS_QUIET},
            '{LINE_HI,      1, 1'b0, STATUS_QUIET},
            '{LINE_HI,      2, 1'b0, STATUS_QUIET},
            '{LINE_LO,      1, 1'b0, STATUS_QUIET},
            '{LINE_LO,      2, 1'b0, STATUS_QUIET},
            '{LINE_HI_END,  1, 1'b0, STATUS_QUIET},
            '{LINE_LO,      1, 1'b1, STATUS_SHORT_SLOT1},
            '{LINE_LO_END,  1, 1'b0, STATUS_QUIET}
        };

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 11; i++)
        begin
            repeat (directed[i].count)
                send_item(directed[i].stim, directed[i].typed, directed[i].want);
        end

        hold_pending <= 1'b1;
        run_random(50);

        write_config('0);
        run_random(15);

        // Every bound at its top value; the tick counter must saturate to reach them.
        write_config('1);
        send_run(1'b0, 1'b1, 256);
        send_run(1'b1, 1'b1, 2);
        send_run(1'b0, 1'b1, 3);
        send_run(1'b1, 1'b0, 2);

        write_config(random_timing_cfg());
        quiet <= 1'b1;
        run_random(40);
        quiet <= 1'b0;

        c.sample_tick = 8'd5;
        c.start_low_min = 8'd20;
        c.start_low_max = 8'd10;
        c.start_period_min = 8'd30;
        c.start_period_max = 8'd25;
        c.bit_period_min = 8'd12;
        c.bit_period_max = 8'd8;
        write_config(c);
        run_random(15);

        write_config(random_timing_cfg());
        run_random(15);
        wait_drained();
        run_random(15);

        wait_drained();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
